// ===== rtl/cvblas1_pkg.sv =====
// types, formats and codes shared by the complex vector blas level-1 unit
package cvblas1_pkg;

	// data and accumulator formats
	localparam int DATA_BITS = 16;
	localparam int ACC_BITS  = 48;
	localparam int COEF_BITS = 18;
	localparam int COEF_FRAC = 14;

	// operation codes
	localparam logic OP_AXPBY = 1'b0;
	localparam logic OP_DOT   = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_A_REAL = 2'd0,
		CFG_A_IMAG = 2'd1,
		CFG_B_REAL = 2'd2,
		CFG_B_IMAG = 2'd3
	} cfg_index_t;

	// coefficient reset values, Q3.14
	localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1) << COEF_FRAC;
	localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

	typedef struct packed {
		logic                        op;
		logic signed [DATA_BITS-1:0] x_real;
		logic signed [DATA_BITS-1:0] x_imag;
		logic signed [DATA_BITS-1:0] y_real;
		logic signed [DATA_BITS-1:0] y_imag;
		logic                        last;
	} item_t;

	typedef struct packed {
		logic                        is_sum;
		logic signed [DATA_BITS-1:0] elem_real;
		logic signed [DATA_BITS-1:0] elem_imag;
		logic                        elem_clipped;
		logic signed [ACC_BITS-1:0]  sum_real;
		logic signed [ACC_BITS-1:0]  sum_imag;
		logic                        sum_clipped;
	} result_t;

endpackage

// ===== rtl/complex_vector_blas1_unit.sv =====
// complex vector blas level-1 unit: axpby elements and conjugated dot product
// pipeline: an item passes the input register and then the output register, from which
//   its result is on offer
// throughput: one item per cycle unless stalled; the accumulator loop is one add and saturate
//   per cycle; stalls: a waiting result holds back only an item that makes a result
// reset: coefficients return to a = 1.0, b = 1.0; accumulator, clip flag and valids clear
// reset is asynchronous, active low; there is no clearing pass
module complex_vector_blas1_unit
	import cvblas1_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_data,
	// item channel
	input  logic                    item_valid,
	output logic                    item_stall,
	input  item_t                   item,
	// result channel
	output logic                    result_valid,
	input  logic                    result_stall,
	output result_t                 result
);

	// product and sum widths
	localparam int EPW = COEF_BITS + DATA_BITS;     // coefficient times data
	localparam int ESW = EPW + 2;                   // sum of four products
	localparam int ERW = ESW - COEF_FRAC;           // after the rounding shift
	localparam int DPW = 2 * DATA_BITS;             // data times data
	localparam int ASW = ACC_BITS + 2;              // accumulator plus two terms

	localparam logic signed [ESW-1:0] ROUND_HALF = ESW'(1) << (COEF_FRAC - 1);
	localparam logic signed [DATA_BITS-1:0] DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
	localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
	localparam logic signed [ACC_BITS-1:0]  ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0]  ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};

	// coefficient registers
	logic signed [COEF_BITS-1:0] coef_a_real_q, coef_a_imag_q, coef_b_real_q, coef_b_imag_q;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// accumulator
	logic signed [ACC_BITS-1:0] acc_real_q, acc_imag_q;
	logic                       acc_clipped_q;

	// output register
	logic    result_valid_q;
	result_t result_q;

	// flow control
	logic item_xfer, out_free, produces_s1, adv_s1, load_out;

	// ---------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_real_q <= COEF_ONE;
			coef_a_imag_q <= COEF_ZERO;
			coef_b_real_q <= COEF_ONE;
			coef_b_imag_q <= COEF_ZERO;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_A_REAL: coef_a_real_q <= cfg_data;
				CFG_A_IMAG: coef_a_imag_q <= cfg_data;
				CFG_B_REAL: coef_b_real_q <= cfg_data;
				CFG_B_IMAG: coef_b_imag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake and pipeline advance
	// ---------------------------------------------------------------
	// output slot is free when empty or its result transfers this cycle
	assign out_free    = !result_valid_q || !result_stall;
	// elementwise items and the last dot item make a result
	assign produces_s1 = (item_s1.op == OP_AXPBY) || item_s1.last;
	// a dot item that is not last only touches the accumulator, never waits
	assign adv_s1      = valid_s1 && (!produces_s1 || out_free);
	assign load_out    = adv_s1 && produces_s1;
	assign item_stall  = valid_s1 && !adv_s1;
	assign item_xfer   = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_xfer || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_s1 <= item;
		end
	end

	// ---------------------------------------------------------------
	// elementwise a*x + b*y
	// ---------------------------------------------------------------
	logic signed [EPW-1:0] p_ar_xr, p_ai_xi, p_br_yr, p_bi_yi;
	logic signed [EPW-1:0] p_ar_xi, p_ai_xr, p_br_yi, p_bi_yr;
	logic signed [ESW-1:0] elem_re_sum, elem_im_sum;
	logic        [ERW-1:0] elem_re_rnd, elem_im_rnd;
	logic signed [DATA_BITS-1:0] elem_re_sat, elem_im_sat;
	logic        elem_re_clip, elem_im_clip;

	assign p_ar_xr = EPW'(coef_a_real_q) * EPW'(item_s1.x_real);
	assign p_ai_xi = EPW'(coef_a_imag_q) * EPW'(item_s1.x_imag);
	assign p_br_yr = EPW'(coef_b_real_q) * EPW'(item_s1.y_real);
	assign p_bi_yi = EPW'(coef_b_imag_q) * EPW'(item_s1.y_imag);
	assign p_ar_xi = EPW'(coef_a_real_q) * EPW'(item_s1.x_imag);
	assign p_ai_xr = EPW'(coef_a_imag_q) * EPW'(item_s1.x_real);
	assign p_br_yi = EPW'(coef_b_real_q) * EPW'(item_s1.y_imag);
	assign p_bi_yr = EPW'(coef_b_imag_q) * EPW'(item_s1.y_real);

	// exact sums, then round half up and floor shift
	assign elem_re_sum = ESW'(p_ar_xr) - ESW'(p_ai_xi) + ESW'(p_br_yr) - ESW'(p_bi_yi);
	assign elem_im_sum = ESW'(p_ar_xi) + ESW'(p_ai_xr) + ESW'(p_br_yi) + ESW'(p_bi_yr);

	logic signed [ESW-1:0] elem_re_half, elem_im_half;
	assign elem_re_half = elem_re_sum + ROUND_HALF;
	assign elem_im_half = elem_im_sum + ROUND_HALF;
	assign elem_re_rnd  = elem_re_half[ESW-1:COEF_FRAC];
	assign elem_im_rnd  = elem_im_half[ESW-1:COEF_FRAC];

	// out of range when the data sign bit and the bits above it disagree
	assign elem_re_clip = !((&elem_re_rnd[ERW-1:DATA_BITS-1]) || !(|elem_re_rnd[ERW-1:DATA_BITS-1]));
	assign elem_im_clip = !((&elem_im_rnd[ERW-1:DATA_BITS-1]) || !(|elem_im_rnd[ERW-1:DATA_BITS-1]));
	assign elem_re_sat  = elem_re_clip ? (elem_re_rnd[ERW-1] ? DATA_MIN : DATA_MAX)
	                                   : elem_re_rnd[DATA_BITS-1:0];
	assign elem_im_sat  = elem_im_clip ? (elem_im_rnd[ERW-1] ? DATA_MIN : DATA_MAX)
	                                   : elem_im_rnd[DATA_BITS-1:0];

	// ---------------------------------------------------------------
	// dot product conj(x) * y into the accumulator
	// ---------------------------------------------------------------
	logic signed [DPW-1:0] p_xr_yr, p_xi_yi, p_xr_yi, p_xi_yr;
	logic signed [ASW-1:0] acc_re_sum, acc_im_sum;
	logic signed [ACC_BITS-1:0] acc_re_sat, acc_im_sat;
	logic acc_re_clip, acc_im_clip, sum_clip;

	assign p_xr_yr = DPW'(item_s1.x_real) * DPW'(item_s1.y_real);
	assign p_xi_yi = DPW'(item_s1.x_imag) * DPW'(item_s1.y_imag);
	assign p_xr_yi = DPW'(item_s1.x_real) * DPW'(item_s1.y_imag);
	assign p_xi_yr = DPW'(item_s1.x_imag) * DPW'(item_s1.y_real);

	assign acc_re_sum = ASW'(acc_real_q) + ASW'(p_xr_yr) + ASW'(p_xi_yi);
	assign acc_im_sum = ASW'(acc_imag_q) + ASW'(p_xr_yi) - ASW'(p_xi_yr);

	assign acc_re_clip = !((&acc_re_sum[ASW-1:ACC_BITS-1]) || !(|acc_re_sum[ASW-1:ACC_BITS-1]));
	assign acc_im_clip = !((&acc_im_sum[ASW-1:ACC_BITS-1]) || !(|acc_im_sum[ASW-1:ACC_BITS-1]));
	assign acc_re_sat  = acc_re_clip ? (acc_re_sum[ASW-1] ? ACC_MIN : ACC_MAX)
	                                 : acc_re_sum[ACC_BITS-1:0];
	assign acc_im_sat  = acc_im_clip ? (acc_im_sum[ASW-1] ? ACC_MIN : ACC_MAX)
	                                 : acc_im_sum[ACC_BITS-1:0];
	// sticky flag for the whole vector, including this element
	assign sum_clip    = acc_clipped_q || acc_re_clip || acc_im_clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_real_q    <= '0;
			acc_imag_q    <= '0;
			acc_clipped_q <= 1'b0;
		end else if (adv_s1 && (item_s1.op == OP_DOT)) begin
			if (item_s1.last) begin
				// sum goes out, accumulator starts the next vector clean
				acc_real_q    <= '0;
				acc_imag_q    <= '0;
				acc_clipped_q <= 1'b0;
			end else begin
				acc_real_q    <= acc_re_sat;
				acc_imag_q    <= acc_im_sat;
				acc_clipped_q <= sum_clip;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load_out) begin
			if (item_s1.op == OP_AXPBY) begin
				result_q.is_sum       <= 1'b0;
				result_q.elem_real    <= elem_re_sat;
				result_q.elem_imag    <= elem_im_sat;
				result_q.elem_clipped <= elem_re_clip || elem_im_clip;
				result_q.sum_real     <= '0;
				result_q.sum_imag     <= '0;
				result_q.sum_clipped  <= 1'b0;
			end else begin
				result_q.is_sum       <= 1'b1;
				result_q.elem_real    <= '0;
				result_q.elem_imag    <= '0;
				result_q.elem_clipped <= 1'b0;
				result_q.sum_real     <= acc_re_sat;
				result_q.sum_imag     <= acc_im_sat;
				result_q.sum_clipped  <= sum_clip;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// a finished vector leaves a clean accumulator
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (item_s1.op == OP_DOT) && item_s1.last
		|=> (acc_real_q == '0) && (acc_imag_q == '0) && !acc_clipped_q)
		else $error("accumulator not cleared after last dot item");

	// an elementwise item always shows up as an element result next cycle
	a_elem_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (item_s1.op == OP_AXPBY) |=> result_valid_q && !result_q.is_sum)
		else $error("elementwise item lost");

	// a dot item that is not last never produces a result
	a_dot_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (item_s1.op == OP_DOT) && !item_s1.last && !(result_valid_q && result_stall)
		|=> !result_valid_q)
		else $error("result from a dot item that is not last");

	// a clipped element sits at a rail in at least one part
	a_elem_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.elem_clipped
		|-> (result_q.elem_real == DATA_MAX) || (result_q.elem_real == DATA_MIN) ||
		    (result_q.elem_imag == DATA_MAX) || (result_q.elem_imag == DATA_MIN))
		else $error("clip flag without saturated element");

endmodule
